// File: rtl/qti_pkg.sv
package qti_pkg;

    localparam int DEPTH_DEF      = 4;
    localparam int COUNT_BITS_DEF = 16;
    localparam int COORD_BITS_DEF = 16;

    localparam int POS_W   = 16;
    localparam int HALF_W  = 15;
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 8;
    localparam int LCNT_W  = 16;
    localparam int CFG_N   = 2;
    localparam int CFG_AW  = 1;
    localparam int CFG_DW  = 15;

    localparam logic [CFG_AW-1:0] CFG_HALF_WIDTH  = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_HALF_HEIGHT = 1'd1;

    localparam logic [HALF_W-1:0] HALF_RESET = 15'd512;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                    cmd;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } t_item;

    typedef struct packed {
        logic idle;
        logic clearing;
    } t_back_stat;

endpackage

// File: rtl/qti_ram.sv
module qti_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 85,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/qti_front.sv
module qti_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_cmd,
    input  logic signed [15:0]  i_pos_x,
    input  logic signed [15:0]  i_pos_y,
    input  qti_pkg::t_back_stat i_stat,
    output logic                o_busy,
    output logic                o_valid,
    output qti_pkg::t_item      o_item
);
    import qti_pkg::*;

    // two-entry queue toward the back end
    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;
    t_item      w_in;

    always_comb begin
        w_in.pos_x = i_pos_x;
        w_in.pos_y = i_pos_y;
        w_in.cmd   = t_cmd'(i_cmd);
    end

    assign o_busy  = (r_cnt == 2'd2) || i_stat.clearing;
    assign w_push  = i_start && !o_busy;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && i_stat.idle;
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |=> r_cnt != 2'd0 || $past(w_pop)) else $error("queue count");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue overflow");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
endmodule

// File: rtl/qti_back.sv
module qti_back #(
    parameter int DEPTH      = qti_pkg::DEPTH_DEF,
    parameter int COUNT_BITS = qti_pkg::COUNT_BITS_DEF,
    parameter int COORD_BITS = qti_pkg::COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [14:0]         i_half_width,
    input  logic [14:0]         i_half_height,
    input  logic                i_valid,
    input  qti_pkg::t_item      i_item,
    output qti_pkg::t_back_stat o_stat,
    output logic                o_done,
    output logic                o_found,
    output logic [7:0]          o_leaf_index,
    output logic [15:0]         o_leaf_count
);
    import qti_pkg::*;

    localparam int ROWS = ((4 ** DEPTH) - 1) / 3;
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LW   = $clog2(DEPTH + 1);
    localparam int RW   = 4 * COUNT_BITS;
    localparam int EW   = (COORD_BITS > POS_W) ? COORD_BITS : POS_W;
    localparam logic [LW-1:0] LAST_LVL = LW'(DEPTH - 1);
    localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {S_CLR, S_IDLE, S_RD, S_EVAL} t_state;

    t_state                       r_state;
    t_item                        r_item;
    logic [COUNT_BITS-1:0]        r_root;
    logic [AW-1:0]                r_node;
    logic [AW-1:0]                r_clr;
    logic [LW-1:0]                r_lvl;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic [HALF_W-1:0]            r_w, r_h;
    logic [IDX_W-1:0]             r_path;
    logic                         r_done, r_found;
    logic [LCNT_W-1:0]            r_lcnt;

    logic                  w_we;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [RW-1:0]         w_wdata, w_rdata;
    logic [COUNT_BITS-1:0] w_cnt [4];
    logic [1:0]            w_own, w_q;
    logic [COUNT_BITS-1:0] w_sel, w_inc;
    logic [HALF_W-1:0]     w_cw, w_ch;
    logic signed [COORD_BITS-1:0] w_npx, w_npy;
    logic [AW+2:0]         w_next_wide;
    logic [AW-1:0]         w_next;
    logic [COUNT_BITS+LCNT_W-1:0] w_ext;
    logic                  w_ins;

    qti_ram #(.WIDTH(RW), .DEPTH(ROWS), .AW(AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_cnt[k] = w_rdata[k*COUNT_BITS +: COUNT_BITS];
        end
        w_own[1] = (EW'(r_item.pos_x) <= EW'(r_px));
        w_own[0] = (EW'(r_item.pos_y) <= EW'(r_py));
        w_ins    = (r_item.cmd == CMD_INSERT);
        // a nonzero node always has a nonzero child, so no backtracking
        priority if (w_ins || w_cnt[w_own] != '0) w_q = w_own;
        else if (w_cnt[0] != '0)                  w_q = 2'd0;
        else if (w_cnt[1] != '0)                  w_q = 2'd1;
        else if (w_cnt[2] != '0)                  w_q = 2'd2;
        else                                      w_q = 2'd3;
        w_sel = w_cnt[w_q];
        w_inc = (w_sel == CNT_MAX) ? w_sel : w_sel + 1'b1;
        w_cw  = r_w >> 1;
        w_ch  = r_h >> 1;
        w_npx = w_q[1] ? r_px - COORD_BITS'(w_cw) : r_px + COORD_BITS'(w_cw);
        w_npy = w_q[0] ? r_py - COORD_BITS'(w_ch) : r_py + COORD_BITS'(w_ch);
        w_next_wide = {1'b0, r_node, 2'b00} + (AW+3)'(w_q) + (AW+3)'(1);
        w_next = w_next_wide[AW-1:0];
        w_ext  = (COUNT_BITS+LCNT_W)'(w_ins ? w_inc : w_sel);

        w_we    = 1'b0;
        w_waddr = r_node;
        w_wdata = w_rdata;
        w_wdata[w_q*COUNT_BITS +: COUNT_BITS] = w_inc;
        if (r_state == S_CLR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (r_state == S_EVAL && w_ins) begin
            w_we = 1'b1;
        end
        w_raddr = (r_state == S_EVAL) ? w_next : r_node;
    end

    assign o_stat.idle     = (r_state == S_IDLE);
    assign o_stat.clearing = (r_state == S_CLR);
    assign o_done          = r_done;
    assign o_found         = r_found;
    assign o_leaf_index    = r_path;
    assign o_leaf_count    = r_lcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_root  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST_ROW) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_item  <= i_item;
                        r_node  <= '0;
                        r_lvl   <= '0;
                        r_px    <= '0;
                        r_py    <= '0;
                        r_w     <= i_half_width;
                        r_h     <= i_half_height;
                        r_path  <= '0;
                        r_found <= 1'b0;
                        r_lcnt  <= '0;
                        unique case (i_item.cmd)
                            CMD_INSERT: begin
                                if (r_root != CNT_MAX) r_root <= r_root + 1'b1;
                                r_state <= S_RD;
                            end
                            CMD_QUERY: begin
                                if (r_root != '0) r_state <= S_RD;
                                else              r_done  <= 1'b1;
                            end
                            CMD_CLEAR: begin
                                r_root  <= '0;
                                r_clr   <= '0;
                                r_done  <= 1'b1;
                                r_state <= S_CLR;
                            end
                            default: r_done <= 1'b1;
                        endcase
                    end
                end
                S_RD: r_state <= S_EVAL;
                S_EVAL: begin
                    r_px   <= w_npx;
                    r_py   <= w_npy;
                    r_w    <= w_cw;
                    r_h    <= w_ch;
                    r_node <= w_next;
                    r_lvl  <= r_lvl + 1'b1;
                    r_path <= {r_path[IDX_W-3:0], w_q};
                    if (r_lvl == LAST_LVL) begin
                        r_found <= 1'b1;
                        r_lcnt  <= w_ext[LCNT_W-1:0];
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE || r_state == S_CLR))
        else $error("result while walking");
    a_write_when: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> r_state == S_CLR || (r_state == S_EVAL && w_ins))
        else $error("stray count write");
    a_insert_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_item.cmd == CMD_INSERT && $past(r_state == S_EVAL) |-> r_found)
        else $error("insert not found");
    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EVAL |-> r_lvl <= LAST_LVL) else $error("level overrun");
endmodule

// File: rtl/fixed_depth_quadtree_index_top.sv
// Fixed-depth quadtree occupancy index. Raise start with a command while busy is low:
// insert bumps the counts of every node on the point's path, query walks to the first
// occupied leaf (own quadrant first), clear zeroes all counts. Each command gives exactly
// one result on o_done for one cycle, which the receiver cannot stall. Insert and a query
// of a nonempty tree read one four-child row of the count memory per level as they walk
// from the root to a leaf; the other commands give their result from the idle state.
// An item reaches the back end in the cycle after it is accepted when the back end is
// idle, and a two-entry queue holds commands while the back end works. After reset and
// after every clear the count memory is swept, one row at a time over its (4^DEPTH-1)/3
// rows (85 at DEPTH 4), with busy high.
module fixed_depth_quadtree_index_top #(
    parameter int DEPTH      = qti_pkg::DEPTH_DEF,
    parameter int COUNT_BITS = qti_pkg::COUNT_BITS_DEF,
    parameter int COORD_BITS = qti_pkg::COORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [14:0]        i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    output logic               o_done,
    output logic               o_found,
    output logic [7:0]         o_leaf_index,
    output logic [15:0]        o_leaf_count
);
    import qti_pkg::*;

    logic [HALF_W-1:0] r_half_w, r_half_h;
    t_back_stat        w_stat;
    logic              w_valid;
    t_item             w_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_w <= HALF_RESET;
            r_half_h <= HALF_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HALF_WIDTH:  r_half_w <= i_cfg_data;
                CFG_HALF_HEIGHT: r_half_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    qti_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_cmd  (i_cmd),
        .i_pos_x(i_pos_x),
        .i_pos_y(i_pos_y),
        .i_stat (w_stat),
        .o_busy (busy),
        .o_valid(w_valid),
        .o_item (w_item)
    );

    qti_back #(
        .DEPTH     (DEPTH),
        .COUNT_BITS(COUNT_BITS),
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_half_width (r_half_w),
        .i_half_height(r_half_h),
        .i_valid      (w_valid),
        .i_item       (w_item),
        .o_stat       (w_stat),
        .o_done       (o_done),
        .o_found      (o_found),
        .o_leaf_index (o_leaf_index),
        .o_leaf_count (o_leaf_count)
    );
endmodule
